// ----- sv/aes_inverse_round_assert.svh -----
// Assertion macros for the AES inverse round block.
// Used by aes_inverse_round; expects aclk and aresetn in scope.
`ifndef AES_INVERSE_ROUND_ASSERT_SVH
`define AES_INVERSE_ROUND_ASSERT_SVH

// same-cycle implication
`define AIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/air_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and GF(2^8) helpers for the AES inverse round.
// No dependencies; used by air_sub_shift, air_inv_mix and aes_inverse_round.
package air_pkg;

    typedef logic [7:0]       byte_t;
    typedef logic [0:15][7:0] blk_t;

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
    };

    // multiply by x modulo x^8+x^4+x^3+x+1
    function automatic byte_t xtime(input byte_t b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ----- sv/air_sub_shift.sv -----
`timescale 1ns / 1ps
// InvShiftRows, InvSubBytes and round key XOR for one 16-byte block.
// Depends on air_pkg (blk_t, INV_SBOX).
module air_sub_shift import air_pkg::*; (
    input  blk_t blk_in,
    input  blk_t round_key,
    output blk_t blk_out
);

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                blk_out[r * 4 + c] = INV_SBOX[blk_in[r * 4 + ((c - r + 4) % 4)]]
                                     ^ round_key[r * 4 + c];
            end
        end
    end

endmodule

// ----- sv/air_inv_mix.sv -----
`timescale 1ns / 1ps
// InvMixColumns over the four columns, bypassed on the final round.
// Depends on air_pkg (blk_t, byte_t, xtime).
module air_inv_mix import air_pkg::*; (
    input  logic final_rnd,
    input  blk_t blk_in,
    output blk_t blk_out
);

    blk_t mixed;

    always_comb begin
        byte_t b  [4];
        byte_t m9 [4];
        byte_t mb [4];
        byte_t md [4];
        byte_t me [4];
        byte_t x2;
        byte_t x4;
        byte_t x8;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                b[i]  = blk_in[i * 4 + c];
                x2    = xtime(b[i]);
                x4    = xtime(x2);
                x8    = xtime(x4);
                m9[i] = x8 ^ b[i];
                mb[i] = x8 ^ x2 ^ b[i];
                md[i] = x8 ^ x4 ^ b[i];
                me[i] = x8 ^ x4 ^ x2;
            end
            mixed[c]      = me[0] ^ mb[1] ^ md[2] ^ m9[3];
            mixed[c + 4]  = m9[0] ^ me[1] ^ mb[2] ^ md[3];
            mixed[c + 8]  = md[0] ^ m9[1] ^ me[2] ^ mb[3];
            mixed[c + 12] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
        end
    end

    assign blk_out = final_rnd ? blk_in : mixed;

endmodule

// ----- sv/aes_inverse_round.sv -----
`timescale 1ns / 1ps
// Channel  | ports                                           | dir
// ---------+-------------------------------------------------+-----
// input    | s_valid s_ready s_mode s_state_hi/lo s_key_hi/lo | in
// result   | m_valid m_ready m_out_hi m_out_lo                | out
//
// Two register stages: input word register, then result register. The
// round logic between them is one pass, so one word per cycle sustained
// while m_ready is high; m_valid rises when the word moves on from the
// input register into the result register. Synchronous active-low reset
// empties both stages. A stall on m_ready holds the result register; the
// input register keeps filling until it too is occupied.
// Depends on air_pkg, air_sub_shift, air_inv_mix, aes_inverse_round_assert.svh.
`include "aes_inverse_round_assert.svh"

module aes_inverse_round import air_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [63:0] s_state_hi,
    input  logic [63:0] s_state_lo,
    input  logic [63:0] s_key_hi,
    input  logic [63:0] s_key_lo,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_hi,
    output logic [63:0] m_out_lo
);

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic mode1_reg;
    blk_t st1_reg;
    blk_t key1_reg;
    blk_t res_reg;
    blk_t subbed;
    blk_t rnd_out;
    logic adv2;
    logic load1;

    assign adv2  = v1_reg && (!v2_reg || m_ready);
    assign s_ready = !v1_reg || adv2;
    assign load1 = s_valid && s_ready;

    always_comb begin
        v1_next = v1_reg;
        if (load1) begin
            v1_next = 1'b1;
        end else if (adv2) begin
            v1_next = 1'b0;
        end
        v2_next = v2_reg;
        if (adv2) begin
            v2_next = 1'b1;
        end else if (m_ready) begin
            v2_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            mode1_reg <= s_mode;
            st1_reg   <= {s_state_hi, s_state_lo};
            key1_reg  <= {s_key_hi, s_key_lo};
        end
        if (adv2) begin
            res_reg <= rnd_out;
        end
    end

    air_sub_shift u_sub_shift (
        .blk_in    (st1_reg),
        .round_key (key1_reg),
        .blk_out   (subbed)
    );

    air_inv_mix u_inv_mix (
        .final_rnd (mode1_reg),
        .blk_in    (subbed),
        .blk_out   (rnd_out)
    );

    assign m_valid  = v2_reg;
    assign m_out_hi = res_reg[0:7];
    assign m_out_lo = res_reg[8:15];

    `AIR_ASSERT_NEXT(a_load_fills, load1, v1_reg, "accepted word not held in input stage")
    `AIR_ASSERT_NEXT(a_hold_in, v1_reg && !adv2, v1_reg && $stable(st1_reg) && $stable(key1_reg), "input stage overwritten while occupied")
    `AIR_ASSERT_NOW(a_ready_flow, m_ready, s_ready, "input stalled while result side ready")

endmodule
